// File: rtl/utf8v_pkg.sv
// utf8v_pkg: types and byte-range constants for the UTF-8 string validator.
// No dependencies; used by utf8v_decode and utf8_string_validator_top.
package utf8v_pkg;

  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned ReportWidth = 16;

  localparam logic [7:0] ByteNul     = 8'h00;
  localparam logic [7:0] AsciiTop    = 8'h7F;
  localparam logic [7:0] Lead2Lo     = 8'hC2;
  localparam logic [7:0] Lead2Hi     = 8'hDF;
  localparam logic [7:0] Lead3Lo     = 8'hE0;
  localparam logic [7:0] Lead3Hi     = 8'hEF;
  localparam logic [7:0] Lead3Ed     = 8'hED;
  localparam logic [7:0] Lead4Lo     = 8'hF0;
  localparam logic [7:0] Lead4Hi     = 8'hF4;
  localparam logic [7:0] ContLo      = 8'h80;
  localparam logic [7:0] ContHi      = 8'hBF;
  localparam logic [7:0] ContE0Lo    = 8'hA0;
  localparam logic [7:0] ContEdHi    = 8'h9F;
  localparam logic [7:0] ContF0Lo    = 8'h90;
  localparam logic [7:0] ContF4Hi    = 8'h8F;

  // Which narrowed range applies to the second byte of a sequence
  typedef enum logic [2:0] {
    LC_PLAIN = 3'd0,
    LC_E0    = 3'd1,
    LC_ED    = 3'd2,
    LC_F0    = 3'd3,
    LC_F4    = 3'd4
  } lead_class_e;

  // Decoder state carried from byte to byte (character total kept apart)
  typedef struct packed {
    logic [1:0]  bytes_pending;
    lead_class_e lead_class;
    logic        second_due;
    logic        error_seen;
  } dec_state_t;

  localparam dec_state_t DecStateReset = '{
    bytes_pending: 2'd0,
    lead_class:    LC_PLAIN,
    second_due:    1'b0,
    error_seen:    1'b0
  };

endpackage

// File: rtl/utf8_string_validator_top.sv
// utf8_string_validator_top: UTF-8 string checker and character counter.
// Depends on utf8v_pkg and utf8v_decode.
//
//  channel  | dir | tdata                   | tuser             | tlast
//  ---------+-----+-------------------------+-------------------+----------
//  s_axis   | in  | [7:0] data_byte         | -                 | last_byte
//  m_axis   | out | [15:0] char_count       | [0] string_valid  | -
//
// One byte is taken per cycle unless a final byte waits on a full result slot.
// Each byte is held in the input register, then the decode step updates the string
// state; the final byte of a string loads the result register, seen by the sink in
// the next cycle.
// Reset (rst_ni low, asynchronous) clears all valid flags and string state.
// A stalled result only holds back a final byte; other bytes keep flowing.
module utf8_string_validator_top #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] char_count
  output logic        m_axis_tuser_o    // [0] string_valid
);

  // Input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // String state
  utf8v_pkg::dec_state_t   state_q, state_d, state_next;
  logic [COUNT_WIDTH-1:0]  total_q, total_d, total_next;
  logic                    char_done;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_count_q, out_count_d;
  logic        out_ok_q, out_ok_d;

  logic out_free;
  logic step;
  logic s_xfer;
  logic str_ok;
  logic [15:0] total_rep;

  // Output slot free this cycle: empty or being drained by the sink
  assign out_free = !out_valid_q || m_axis_tready_i;
  // Advance the held byte unless it is a final byte facing a full result slot
  assign step     = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready_o = !in_valid_q || step;
  assign s_xfer   = s_axis_tvalid_i && s_axis_tready_o;

  utf8v_decode u_decode (
    .byte_i      (in_byte_q),
    .state_i     (state_q),
    .state_o     (state_next),
    .char_done_o (char_done)
  );

  // Saturating character total
  always_comb begin
    total_next = total_q;
    if (char_done && (total_q != {COUNT_WIDTH{1'b1}})) begin
      total_next = total_q + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
    end
  end

  // Fit the total to the 16-bit report, saturating when wider
  generate
    if (COUNT_WIDTH > utf8v_pkg::ReportWidth) begin : g_wide
      assign total_rep = (|total_next[COUNT_WIDTH-1:utf8v_pkg::ReportWidth]) ?
                         16'hFFFF : total_next[utf8v_pkg::ReportWidth-1:0];
    end else begin : g_narrow
      assign total_rep = 16'(total_next);
    end
  endgenerate

  assign str_ok = !state_next.error_seen && (state_next.bytes_pending == 2'd0);

  always_comb begin
    in_valid_d  = s_xfer || (in_valid_q && !step);
    state_d     = state_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_ok_d    = out_ok_q;
    out_count_d = out_count_q;
    if (step) begin
      if (in_last_q) begin
        // Final byte: emit the result and drop back to the reset state
        state_d     = utf8v_pkg::DecStateReset;
        total_d     = '0;
        out_valid_d = 1'b1;
        out_ok_d    = str_ok;
        out_count_d = str_ok ? total_rep : 16'h0000;
      end else begin
        state_d = state_next;
        total_d = total_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      state_q     <= utf8v_pkg::DecStateReset;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      state_q     <= state_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
    out_ok_q    <= out_ok_d;
    out_count_q <= out_count_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_count_q;
  assign m_axis_tuser_o  = out_ok_q;

endmodule

// File: rtl/utf8v_decode.sv
// utf8v_decode: combinational next-state logic for one byte of the string.
// Depends on utf8v_pkg for the state struct and byte-range constants.
module utf8v_decode (
  input  logic [7:0]            byte_i,
  input  utf8v_pkg::dec_state_t state_i,
  output utf8v_pkg::dec_state_t state_o,
  output logic                  char_done_o
);

  logic [7:0] lo;
  logic [7:0] hi;

  // Continuation range, narrowed for the second byte after special leads
  always_comb begin
    lo = utf8v_pkg::ContLo;
    hi = utf8v_pkg::ContHi;
    if (state_i.second_due) begin
      case (state_i.lead_class)
        utf8v_pkg::LC_E0: lo = utf8v_pkg::ContE0Lo;
        utf8v_pkg::LC_ED: hi = utf8v_pkg::ContEdHi;
        utf8v_pkg::LC_F0: lo = utf8v_pkg::ContF0Lo;
        utf8v_pkg::LC_F4: hi = utf8v_pkg::ContF4Hi;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_o     = state_i;
    char_done_o = 1'b0;
    if (!state_i.error_seen) begin
      if (state_i.bytes_pending == 2'd0) begin
        if (byte_i == utf8v_pkg::ByteNul) begin
          state_o.error_seen = 1'b1;
        end else if (byte_i <= utf8v_pkg::AsciiTop) begin
          char_done_o = 1'b1;
        end else if (byte_i >= utf8v_pkg::Lead2Lo && byte_i <= utf8v_pkg::Lead2Hi) begin
          state_o.bytes_pending = 2'd1;
          state_o.lead_class    = utf8v_pkg::LC_PLAIN;
          state_o.second_due    = 1'b1;
        end else if (byte_i >= utf8v_pkg::Lead3Lo && byte_i <= utf8v_pkg::Lead3Hi) begin
          state_o.bytes_pending = 2'd2;
          state_o.second_due    = 1'b1;
          if (byte_i == utf8v_pkg::Lead3Lo) begin
            state_o.lead_class = utf8v_pkg::LC_E0;
          end else if (byte_i == utf8v_pkg::Lead3Ed) begin
            state_o.lead_class = utf8v_pkg::LC_ED;
          end else begin
            state_o.lead_class = utf8v_pkg::LC_PLAIN;
          end
        end else if (byte_i >= utf8v_pkg::Lead4Lo && byte_i <= utf8v_pkg::Lead4Hi) begin
          state_o.bytes_pending = 2'd3;
          state_o.second_due    = 1'b1;
          if (byte_i == utf8v_pkg::Lead4Lo) begin
            state_o.lead_class = utf8v_pkg::LC_F0;
          end else if (byte_i == utf8v_pkg::Lead4Hi) begin
            state_o.lead_class = utf8v_pkg::LC_F4;
          end else begin
            state_o.lead_class = utf8v_pkg::LC_PLAIN;
          end
        end else begin
          state_o.error_seen = 1'b1;
        end
      end else if (byte_i < lo || byte_i > hi) begin
        state_o.error_seen = 1'b1;
      end else begin
        state_o.bytes_pending = state_i.bytes_pending - 2'd1;
        state_o.second_due    = 1'b0;
        char_done_o           = (state_i.bytes_pending == 2'd1);
      end
    end
  end

endmodule

// File: rtl/utf8v_checker.sv
// utf8v_checker: port-level assertions for utf8_string_validator_top.
// Bound to the top level below; no other dependencies.
module utf8v_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // Input back-pressure only comes from a stalled full result slot
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output back-pressure");

  // An invalid string reports a zero count
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == 16'h0000)
    else $error("invalid string with non-zero count");

  // A valid string holds at least one character
  a_valid_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o != 16'h0000)
    else $error("valid string with zero count");

endmodule

bind utf8_string_validator_top utf8v_checker u_utf8v_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
